// ----- design/owbm_pkg.sv -----
// one-wire bus master package: request codes, sequencer phases, register indexes,
// register reset values and the transfer structs; no dependencies
package owbm_pkg;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_RESET = 2'd1,
    REQ_WRITE = 2'd2,
    REQ_READ  = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_RST_LOW  = 3'd1,
    PH_RST_WAIT = 3'd2,
    PH_RST_TAIL = 3'd3,
    PH_SLOT_LOW = 3'd4,
    PH_SAMPLE   = 3'd5,
    PH_SLOT_REL = 3'd6,
    PH_GAP      = 3'd7
  } phase_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 10;
  localparam int unsigned CountW   = 10;

  localparam logic [CfgIdxW-1:0] CFG_RESET_LOW     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_PRESENCE_WAIT = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_RESET_TAIL    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_WRITE_ONE_LOW = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_SLOT          = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_READ_LOW      = 3'd5;

  localparam logic [9:0] RESET_LOW_RST     = 10'd480;
  localparam logic [9:0] PRESENCE_WAIT_RST = 10'd80;
  localparam logic [9:0] RESET_TAIL_RST    = 10'd400;
  localparam logic [7:0] WRITE_ONE_LOW_RST = 8'd1;
  localparam logic [7:0] SLOT_RST          = 8'd60;
  localparam logic [7:0] READ_LOW_RST      = 8'd2;

  localparam logic [CountW-1:0] COUNT_MAX = '1;
  localparam logic [2:0]        LAST_BIT  = 3'd7;

  typedef struct packed {
    logic [9:0] reset_low_us;
    logic [9:0] presence_wait_us;
    logic [9:0] reset_tail_us;
    logic [7:0] write_one_low_us;
    logic [7:0] slot_us;
    logic [7:0] read_low_us;
  } cfg_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] write_data;
    logic       line_level;
  } in_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_data;
    logic       refused;
  } out_t;

endpackage

// ----- design/owbm_cfg.sv -----
// one-wire bus master timing registers, written through a plain write port
// depends on owbm_pkg
module owbm_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [owbm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [owbm_pkg::CfgDataW-1:0] cfg_wdata_i,
  output owbm_pkg::cfg_t                cfg_o
);

  owbm_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_low_us     <= owbm_pkg::RESET_LOW_RST;
      cfg_q.presence_wait_us <= owbm_pkg::PRESENCE_WAIT_RST;
      cfg_q.reset_tail_us    <= owbm_pkg::RESET_TAIL_RST;
      cfg_q.write_one_low_us <= owbm_pkg::WRITE_ONE_LOW_RST;
      cfg_q.slot_us          <= owbm_pkg::SLOT_RST;
      cfg_q.read_low_us      <= owbm_pkg::READ_LOW_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        owbm_pkg::CFG_RESET_LOW:     cfg_q.reset_low_us     <= cfg_wdata_i;
        owbm_pkg::CFG_PRESENCE_WAIT: cfg_q.presence_wait_us <= cfg_wdata_i;
        owbm_pkg::CFG_RESET_TAIL:    cfg_q.reset_tail_us    <= cfg_wdata_i;
        owbm_pkg::CFG_WRITE_ONE_LOW: cfg_q.write_one_low_us <= cfg_wdata_i[7:0];
        owbm_pkg::CFG_SLOT:          cfg_q.slot_us          <= cfg_wdata_i[7:0];
        owbm_pkg::CFG_READ_LOW:      cfg_q.read_low_us      <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- design/owbm_seq.sv -----
// one-wire bus master sequencer: phase state machine, tick counter, bit shifter
// and the result of each transfer; depends on owbm_pkg
module owbm_seq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  owbm_pkg::cfg_t        cfg_i,
  input  logic                  accept_i,
  input  owbm_pkg::in_t         item_i,
  output owbm_pkg::out_t        res_o
);

  owbm_pkg::phase_e              phase_q, phase_d;
  logic [owbm_pkg::CountW-1:0]   tick_q, tick_d;
  logic [2:0]                    bit_q, bit_d;
  logic [7:0]                    shift_q, shift_d;
  logic                          presence_q, presence_d;
  logic                          drive_q, drive_d;
  logic                          op_read_q, op_read_d;
  logic [7:0]                    last_read_q, last_read_d;

  logic [owbm_pkg::CountW-1:0]   cnt;
  logic [7:0]                    slot_lim;
  logic                          finished;
  logic                          refused;
  logic                          end_bit;

  always_comb begin
    phase_d     = phase_q;
    tick_d      = tick_q;
    bit_d       = bit_q;
    shift_d     = shift_q;
    presence_d  = presence_q;
    drive_d     = drive_q;
    op_read_d   = op_read_q;
    last_read_d = last_read_q;
    finished    = 1'b0;
    refused     = 1'b0;
    end_bit     = 1'b0;
    cnt         = (tick_q == owbm_pkg::COUNT_MAX) ? tick_q : tick_q + 1'b1;
    if (op_read_q) begin
      slot_lim = cfg_i.read_low_us;
    end else if (shift_q[0]) begin
      slot_lim = cfg_i.write_one_low_us;
    end else begin
      slot_lim = cfg_i.slot_us;
    end

    if (item_i.req_type == owbm_pkg::REQ_TICK) begin
      if (phase_q != owbm_pkg::PH_IDLE) begin
        tick_d = cnt;
        case (phase_q)
          owbm_pkg::PH_RST_LOW: begin
            if (cnt >= cfg_i.reset_low_us) begin
              drive_d = 1'b0;
              phase_d = owbm_pkg::PH_RST_WAIT;
              tick_d  = '0;
            end
          end
          owbm_pkg::PH_RST_WAIT: begin
            if (cnt >= cfg_i.presence_wait_us) begin
              presence_d = !item_i.line_level;
              tick_d     = '0;
              if (cfg_i.reset_tail_us == '0) begin
                phase_d  = owbm_pkg::PH_IDLE;
                drive_d  = 1'b0;
                finished = 1'b1;
              end else begin
                phase_d = owbm_pkg::PH_RST_TAIL;
              end
            end
          end
          owbm_pkg::PH_RST_TAIL: begin
            if (cnt >= cfg_i.reset_tail_us) begin
              tick_d   = '0;
              phase_d  = owbm_pkg::PH_IDLE;
              drive_d  = 1'b0;
              finished = 1'b1;
            end
          end
          owbm_pkg::PH_SLOT_LOW: begin
            if (cnt >= {2'b00, slot_lim}) begin
              drive_d = 1'b0;
              tick_d  = '0;
              if (op_read_q) begin
                phase_d = owbm_pkg::PH_SAMPLE;
              end else if (shift_q[0]) begin
                phase_d = owbm_pkg::PH_SLOT_REL;
              end else begin
                end_bit = 1'b1;
              end
            end
          end
          owbm_pkg::PH_SAMPLE: begin
            shift_d = {item_i.line_level, shift_q[7:1]};
            tick_d  = '0;
            phase_d = owbm_pkg::PH_SLOT_REL;
          end
          owbm_pkg::PH_SLOT_REL: begin
            if (cnt >= {2'b00, cfg_i.slot_us}) begin
              tick_d  = '0;
              end_bit = 1'b1;
            end
          end
          owbm_pkg::PH_GAP: begin
            drive_d = 1'b1;
            tick_d  = '0;
            phase_d = owbm_pkg::PH_SLOT_LOW;
          end
          default: begin
            tick_d = '0;
          end
        endcase

        if (end_bit) begin
          if (!op_read_q) begin
            shift_d = {1'b0, shift_q[7:1]};
          end
          if (bit_q == owbm_pkg::LAST_BIT) begin
            if (op_read_q) begin
              last_read_d = shift_q;
            end
            bit_d    = '0;
            phase_d  = owbm_pkg::PH_IDLE;
            drive_d  = 1'b0;
            finished = 1'b1;
          end else begin
            bit_d   = bit_q + 1'b1;
            phase_d = owbm_pkg::PH_GAP;
          end
        end
      end
    end else if (phase_q != owbm_pkg::PH_IDLE) begin
      refused = 1'b1;
    end else begin
      drive_d = 1'b1;
      tick_d  = '0;
      bit_d   = '0;
      if (item_i.req_type == owbm_pkg::REQ_RESET) begin
        phase_d = owbm_pkg::PH_RST_LOW;
      end else begin
        op_read_d = (item_i.req_type == owbm_pkg::REQ_READ);
        shift_d   = op_read_d ? 8'h00 : item_i.write_data;
        phase_d   = owbm_pkg::PH_SLOT_LOW;
      end
    end

    res_o.drive_low = drive_d;
    res_o.busy_res  = (phase_d != owbm_pkg::PH_IDLE);
    res_o.done_res  = finished;
    res_o.presence  = presence_d;
    res_o.read_data = last_read_d;
    res_o.refused   = refused;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= owbm_pkg::PH_IDLE;
      tick_q      <= '0;
      bit_q       <= '0;
      shift_q     <= '0;
      presence_q  <= 1'b0;
      drive_q     <= 1'b0;
      op_read_q   <= 1'b0;
      last_read_q <= '0;
    end else if (accept_i) begin
      phase_q     <= phase_d;
      tick_q      <= tick_d;
      bit_q       <= bit_d;
      shift_q     <= shift_d;
      presence_q  <= presence_d;
      drive_q     <= drive_d;
      op_read_q   <= op_read_d;
      last_read_q <= last_read_d;
    end
  end

  // idle leaves the line released and the counters cleared
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == owbm_pkg::PH_IDLE |-> !drive_q && tick_q == '0 && bit_q == '0)
    else $error("idle with live sequencer state");

  // line is only pulled low during low phases
  a_drive_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drive_q |-> phase_q == owbm_pkg::PH_RST_LOW || phase_q == owbm_pkg::PH_SLOT_LOW)
    else $error("line driven low outside a low phase");

  // a completing transfer leaves the block idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && res_o.done_res |=> phase_q == owbm_pkg::PH_IDLE)
    else $error("done without returning to idle");

  // a refused command leaves the running sequence untouched
  a_refused_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && res_o.refused |=> phase_q == $past(phase_q) && tick_q == $past(tick_q))
    else $error("refused command disturbed the sequence");

endmodule

// ----- design/one_wire_bus_master_top.sv -----
// one-wire bus master top level: handshake, output register, timing registers
// and sequencer; depends on owbm_pkg, owbm_cfg, owbm_seq
//
// Each transfer taken gives exactly one result in the next cycle through a single
// output register; a new transfer is accepted while the previous result is being
// taken, so the rate is one item per cycle while out_ready_i is high, set by the
// sequencer state update between the input port and the output register. Tick
// items (req_type 0) advance a running bus reset, byte write or byte read by one
// microsecond; commands arriving while a sequence runs are refused. Timing
// registers are written through the plain write port and take effect at once.
module one_wire_bus_master_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  owbm_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output owbm_pkg::out_t                out_data_o,
  input  logic                          cfg_we_i,
  input  logic [owbm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [owbm_pkg::CfgDataW-1:0] cfg_wdata_i
);

  owbm_pkg::cfg_t cfg;
  owbm_pkg::out_t res;
  owbm_pkg::out_t out_q;
  logic           out_valid_q;
  logic           accept;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  owbm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  owbm_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .accept_i (accept),
    .item_i   (in_data_i),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- tb/owbm_checker.sv -----
// one-wire bus master checker: follows the request, result and register write ports,
// predicts every result from its own copy of the sequencer and compares field by field
// depends on owbm_pkg
module owbm_checker
  import owbm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  in_t                  in_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  out_t                 out_data_i,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgDataW-1:0]  cfg_wdata_i,
  output int                   errors_o,
  output int                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  cfg_t              timing;
  phase_e            ph;
  logic [CountW-1:0] tcount;
  logic [2:0]        bit_idx;
  logic [7:0]        shreg;
  logic [7:0]        last_rd;
  logic              presence_q;
  logic              drive_q;
  logic              op_read;
  logic              seq_done;
  out_t              owed_results[$];
  out_t              got;
  out_t              want;

  function automatic void close_sequence();
    ph = PH_IDLE;
    drive_q = 1'b0;
    seq_done = 1'b1;
  endfunction

  function automatic void finish_bit();
    if (!op_read) shreg = shreg >> 1;
    if (bit_idx >= LAST_BIT) begin
      if (op_read) last_rd = shreg;
      bit_idx = '0;
      close_sequence();
    end else begin
      bit_idx = bit_idx + 3'd1;
      ph = PH_GAP;
    end
  endfunction

  function automatic out_t master_step(in_t it);
    out_t res;
    int   cnt;
    int   lim;
    logic refused;
    refused = 1'b0;
    seq_done = 1'b0;
    if (req_e'(it.req_type) == REQ_TICK) begin
      if (ph != PH_IDLE) begin
        cnt = (tcount == COUNT_MAX) ? int'(tcount) : int'(tcount) + 1;
        case (ph)
          PH_RST_LOW: begin
            if (cnt >= int'(timing.reset_low_us)) begin
              drive_q = 1'b0;
              ph = PH_RST_WAIT;
              cnt = 0;
            end
          end
          PH_RST_WAIT: begin
            if (cnt >= int'(timing.presence_wait_us)) begin
              presence_q = ~it.line_level;
              cnt = 0;
              if (timing.reset_tail_us == '0) close_sequence();
              else ph = PH_RST_TAIL;
            end
          end
          PH_RST_TAIL: begin
            if (cnt >= int'(timing.reset_tail_us)) begin
              cnt = 0;
              close_sequence();
            end
          end
          PH_SLOT_LOW: begin
            if (op_read) lim = int'(timing.read_low_us);
            else if (shreg[0]) lim = int'(timing.write_one_low_us);
            else lim = int'(timing.slot_us);
            if (cnt >= lim) begin
              drive_q = 1'b0;
              cnt = 0;
              if (op_read) ph = PH_SAMPLE;
              else if (shreg[0]) ph = PH_SLOT_REL;
              else finish_bit();
            end
          end
          PH_SAMPLE: begin
            shreg = {it.line_level, shreg[7:1]};
            cnt = 0;
            ph = PH_SLOT_REL;
          end
          PH_SLOT_REL: begin
            if (cnt >= int'(timing.slot_us)) begin
              cnt = 0;
              finish_bit();
            end
          end
          PH_GAP: begin
            drive_q = 1'b1;
            cnt = 0;
            ph = PH_SLOT_LOW;
          end
          default: cnt = 0;
        endcase
        tcount = cnt[CountW-1:0];
      end
    end else if (ph != PH_IDLE) begin
      refused = 1'b1;
    end else begin
      drive_q = 1'b1;
      tcount = '0;
      bit_idx = '0;
      if (req_e'(it.req_type) == REQ_RESET) begin
        ph = PH_RST_LOW;
      end else begin
        op_read = (req_e'(it.req_type) == REQ_READ);
        shreg = op_read ? 8'h00 : it.write_data;
        ph = PH_SLOT_LOW;
      end
    end
    res.drive_low = drive_q;
    res.busy_res  = (ph != PH_IDLE);
    res.done_res  = seq_done;
    res.presence  = presence_q;
    res.read_data = last_rd;
    res.refused   = refused;
    return res;
  endfunction

  task automatic check_field(string fname, logic [7:0] exp_val, logic [7:0] act_val);
    if (act_val !== exp_val) begin
      errors_o++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, exp_val, act_val);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timing = '{reset_low_us: RESET_LOW_RST, presence_wait_us: PRESENCE_WAIT_RST,
                 reset_tail_us: RESET_TAIL_RST, write_one_low_us: WRITE_ONE_LOW_RST,
                 slot_us: SLOT_RST, read_low_us: READ_LOW_RST};
      ph = PH_IDLE;
      tcount = '0;
      bit_idx = '0;
      shreg = '0;
      last_rd = '0;
      presence_q = 1'b0;
      drive_q = 1'b0;
      op_read = 1'b0;
      seq_done = 1'b0;
      owed_results.delete();
      errors_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_RESET_LOW:     timing.reset_low_us     = cfg_wdata_i;
          CFG_PRESENCE_WAIT: timing.presence_wait_us = cfg_wdata_i;
          CFG_RESET_TAIL:    timing.reset_tail_us    = cfg_wdata_i;
          CFG_WRITE_ONE_LOW: timing.write_one_low_us = cfg_wdata_i[7:0];
          CFG_SLOT:          timing.slot_us          = cfg_wdata_i[7:0];
          CFG_READ_LOW:      timing.read_low_us      = cfg_wdata_i[7:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) owed_results.push_back(master_step(in_data_i));
      if (out_valid_i && out_ready_i) begin
        got = out_data_i;
        if (owed_results.size() == 0) begin
          errors_o++;
          $display("%0t: unexpected result, expected none, got %h", $time, got);
        end else begin
          want = owed_results.pop_front();
          check_field("drive_low", want.drive_low, got.drive_low);
          check_field("busy_res", want.busy_res, got.busy_res);
          check_field("done_res", want.done_res, got.done_res);
          check_field("presence", want.presence, got.presence);
          check_field("read_data", want.read_data, got.read_data);
          check_field("refused", want.refused, got.refused);
        end
      end
      pending_o = owed_results.size();
    end
  end

endmodule

// ----- tb/one_wire_bus_master_top_tb.sv -----
// testbench top for one_wire_bus_master_top: drives reset, byte write and byte read
// sequences with tick transfers under several timing setups and gives the verdict
// depends on owbm_pkg, owbm_checker and the design
module one_wire_bus_master_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import owbm_pkg::*;

  localparam int IDLE_RARE      = 6;
  localparam int IDLE_OFTEN     = 77;
  localparam int RANDOM_ITEMS   = 450;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int QUIESCE_LIMIT  = 10000;
  localparam int DRAIN_CYCLES   = 10;

  logic                clk = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  in_t                 in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_t                out_data;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  int   errors;
  int   pending;
  int   send_idle = 0;
  int   recv_idle = 0;
  int   line_bias = 2;
  int   items_sent = 0;
  int   commands_sent = 0;
  int   results_seen = 0;
  int   refusals_seen = 0;
  int   setups = 0;
  int   stall_cycles = 0;
  int   rand_base;
  logic last_busy = 1'b0;

  int rl_us, pw_us, rt_us, w1_us, sl_us, rd_us;

  always #1 clk = ~clk;

  one_wire_bus_master_top uut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  owbm_checker master_chk (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      last_busy <= out_data.busy_res;
      results_seen <= results_seen + 1;
      refusals_seen <= refusals_seen + out_data.refused;
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic int eff_us(int v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic int seq_ticks(req_e req, logic [7:0] data);
    int n;
    int b;
    n = 0;
    case (req)
      REQ_RESET: n = eff_us(rl_us) + eff_us(pw_us) + rt_us + 1;
      REQ_WRITE: begin
        for (b = 0; b < 8; b++) begin
          n += (data[b] ? eff_us(w1_us) + eff_us(sl_us) : eff_us(sl_us)) + 1;
        end
      end
      REQ_READ: n = 8 * (eff_us(rd_us) + eff_us(sl_us) + 2);
      default: n = 0;
    endcase
    return n;
  endfunction

  function automatic logic line_pick();
    case (line_bias)
      0: return 1'b0;
      1: return 1'b1;
      default: return 1'($urandom_range(0, 1));
    endcase
  endfunction

  function automatic int rand_us();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return r;
    return $urandom_range(2, 6);
  endfunction

  task automatic set_idle(int s, int r);
    send_idle = s;
    recv_idle = r;
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, int value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= value[CfgDataW-1:0];
    @(negedge clk);
  endtask

  task automatic set_timing(int rl, int pw, int rt, int w1, int sl, int rd);
    write_reg(CFG_RESET_LOW, rl);
    write_reg(CFG_PRESENCE_WAIT, pw);
    write_reg(CFG_RESET_TAIL, rt);
    write_reg(CFG_WRITE_ONE_LOW, w1);
    write_reg(CFG_SLOT, sl);
    write_reg(CFG_READ_LOW, rd);
    cfg_we <= 1'b0;
    rl_us = rl;
    pw_us = pw;
    rt_us = rt;
    w1_us = w1;
    sl_us = sl;
    rd_us = rd;
    setups++;
  endtask

  task automatic send_item(req_e req, logic [7:0] data, logic line);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{req_type: req, write_data: data, line_level: line};
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    items_sent++;
    if (req != REQ_TICK) commands_sent++;
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // tick until the last result shows the master idle
  task automatic quiesce();
    int guard;
    guard = 0;
    wait_drain();
    while (last_busy) begin
      if (guard >= QUIESCE_LIMIT) begin
        $display("%0t: master still busy after %0d ticks", $time, QUIESCE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
      guard++;
      send_item(REQ_TICK, 8'($urandom_range(0, 255)), line_pick());
      wait_drain();
    end
  endtask

  task automatic random_sequence();
    req_e       req;
    logic [7:0] data;
    int         n;
    req = req_e'($urandom_range(1, 3));
    data = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 7) == 0) wait_drain();
    send_item(req, data, 1'($urandom_range(0, 1)));
    n = seq_ticks(req, data) + $urandom_range(0, 3);
    // cut short so that the next command lands on a busy master
    if ($urandom_range(0, 7) == 0) n = n / 2;
    repeat (n) begin
      if ($urandom_range(0, 99) < 3) begin
        send_item(req_e'($urandom_range(1, 3)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
      end else begin
        send_item(REQ_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    rl_us = int'(RESET_LOW_RST);
    pw_us = int'(PRESENCE_WAIT_RST);
    rt_us = int'(RESET_TAIL_RST);
    w1_us = int'(WRITE_ONE_LOW_RST);
    sl_us = int'(SLOT_RST);
    rd_us = int'(READ_LOW_RST);
    set_idle(IDLE_RARE, IDLE_OFTEN);
    repeat (6) @(negedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);

    // first slots of one byte under the reset timing values, then shortened
    send_item(REQ_WRITE, 8'h96, 1'b0);
    repeat (70) send_item(REQ_TICK, 8'h00, line_pick());
    wait_drain();

    set_timing(2, 1, 0, 1, 1, 1);
    quiesce();
    send_item(REQ_TICK, 8'hff, 1'b0);
    send_item(REQ_TICK, 8'h00, 1'b1);
    line_bias = 0;
    send_item(REQ_RESET, 8'h00, 1'b1);
    send_item(REQ_WRITE, 8'hff, 1'b0);
    send_item(REQ_TICK, 8'h00, 1'b0);
    send_item(REQ_READ, 8'h00, 1'b1);
    quiesce();
    line_bias = 1;
    send_item(REQ_RESET, 8'hff, 1'b0);
    quiesce();
    send_item(REQ_WRITE, 8'hff, 1'b1);
    quiesce();
    send_item(REQ_WRITE, 8'h00, 1'b0);
    quiesce();
    send_item(REQ_READ, 8'h5a, 1'b0);
    quiesce();
    line_bias = 0;
    send_item(REQ_READ, 8'ha5, 1'b1);
    quiesce();

    // zero in every register
    set_timing(0, 0, 0, 0, 0, 0);
    line_bias = 2;
    send_item(REQ_RESET, 8'h3c, 1'b0);
    quiesce();
    send_item(REQ_WRITE, 8'hc3, 1'b1);
    quiesce();
    send_item(REQ_READ, 8'h00, 1'b0);
    quiesce();

    rand_base = items_sent;
    while (items_sent - rand_base < RANDOM_ITEMS) begin
      if (items_sent - rand_base < RANDOM_ITEMS / 3) set_idle(IDLE_RARE, IDLE_OFTEN);
      else if (items_sent - rand_base < 2 * RANDOM_ITEMS / 3) set_idle(IDLE_OFTEN, IDLE_RARE);
      else set_idle(0, 0);
      if ($urandom_range(0, 2) == 0) begin
        quiesce();
        set_timing(rand_us(), rand_us(), rand_us(), rand_us(), rand_us(), rand_us());
      end
      repeat (3) random_sequence();
    end

    // widest timing values, cut back while the sequence runs
    quiesce();
    set_timing(1023, 1023, 1023, 255, 255, 255);
    send_item(REQ_RESET, 8'h81, 1'b1);
    repeat (20) send_item(REQ_TICK, 8'h00, line_pick());
    wait_drain();
    set_timing(3, 2, 1, 2, 3, 2);
    quiesce();
    set_timing(1023, 1023, 1023, 255, 255, 255);
    send_item(REQ_READ, 8'h7e, 1'b0);
    repeat (20) send_item(REQ_TICK, 8'h00, line_pick());
    wait_drain();
    set_timing(3, 2, 1, 2, 3, 2);
    quiesce();

    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("covered %0d transfers in, %0d commands, %0d refused, %0d results checked",
             items_sent, commands_sent, refusals_seen, results_seen);
    $display("over %0d timing setups from all zeros to full range", setups);
    if (pending != 0) $display("%0d results never arrived", pending);
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
